/* hw/rtl/sld_pkg.sv */
// Shared types, constants and the glyph ROM of the scrolling LED matrix driver.
package sld_pkg;

  localparam int GLYPH_ROWS   = 24;
  localparam int GLYPH_COUNT  = 4;
  localparam int STORED_ROWS  = 24;
  localparam int PRIO_W       = 3;
  localparam int GLYPH_W      = 2;
  localparam int SCAN_W       = 3;
  localparam int PERIOD_W     = 8;
  localparam int COL_W        = 8;
  // Position runs to GLYPH_ROWS+9 and the window top adds up to seven more.
  localparam int POS_W        = $clog2(GLYPH_ROWS + 17);
  localparam int ROM_IDX_W    = $clog2(STORED_ROWS);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(200);
  localparam logic [POS_W-1:0]    RETIRE_POS   = POS_W'(GLYPH_ROWS + 8);
  localparam logic [POS_W-1:0]    WINDOW_OFS   = POS_W'(7);
  localparam logic [PRIO_W-1:0]   PRIO_EMPTY   = '0;

  typedef enum logic {
    KIND_TICK    = 1'b0,
    KIND_REQUEST = 1'b1
  } kind_t;

  typedef struct packed {
    logic [PRIO_W-1:0]   work_prio;
    logic [GLYPH_W-1:0]  work_glyph;
    logic [POS_W-1:0]    position;
    logic [PRIO_W-1:0]   pend_prio;
    logic [GLYPH_W-1:0]  pend_glyph;
    logic [PERIOD_W-1:0] prescale;
    logic [SCAN_W-1:0]   scan_row;
  } state_t;

  typedef struct packed {
    logic               drive;
    logic               clear;
    logic [SCAN_W-1:0]  row_off;
    logic [SCAN_W-1:0]  row_on;
    logic [COL_W-1:0]   columns;
    logic               busy_res;
  } result_t;

  localparam logic [COL_W-1:0] GLYPH_ROM [4][STORED_ROWS] = '{
    '{8'h18, 8'h3C, 8'h66, 8'hC3, 8'h81, 8'h18, 8'h3C, 8'h66,
      8'hC3, 8'h81, 8'h18, 8'h3C, 8'h66, 8'hC3, 8'h81, 8'h00,
      8'hE1, 8'h33, 8'h1B, 8'h0F, 8'h1F, 8'h33, 8'h63, 8'hE3},
    '{8'h18, 8'h3C, 8'h66, 8'hC3, 8'h81, 8'h18, 8'h3C, 8'h66,
      8'hC3, 8'h81, 8'h18, 8'h3C, 8'h66, 8'hC3, 8'h81, 8'h00,
      8'h24, 8'h66, 8'h66, 8'h7E, 8'hDB, 8'hDB, 8'h99, 8'h81},
    '{8'h18, 8'h3C, 8'h66, 8'hC3, 8'h81, 8'h18, 8'h3C, 8'h66,
      8'hC3, 8'h81, 8'h18, 8'h3C, 8'h66, 8'hC3, 8'h81, 8'h00,
      8'h00, 8'hC3, 8'h66, 8'h66, 8'h66, 8'h24, 8'h3C, 8'h18},
    '{8'hC3, 8'h66, 8'h3C, 8'h18, 8'h3C, 8'h66, 8'hC3, 8'h00,
      8'hC3, 8'h66, 8'h3C, 8'h18, 8'h3C, 8'h66, 8'hC3, 8'h00,
      8'hC3, 8'h66, 8'h3C, 8'h18, 8'h3C, 8'h66, 8'hC3, 8'h81}
  };

  // Rows past the stored patterns read as blank.
  function automatic logic [COL_W-1:0] glyph_row(logic [GLYPH_W-1:0] g,
                                                 logic [POS_W-1:0] r);
    logic [COL_W-1:0] val;
    val = '0;
    if (r < POS_W'(STORED_ROWS)) begin
      val = GLYPH_ROM[g][r[ROM_IDX_W-1:0]];
    end
    return val;
  endfunction

endpackage

/* hw/rtl/sld_if.sv */
// Handshake channel interfaces for items, results and the period register.
interface sld_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [sld_pkg::GLYPH_W-1:0] glyph_id;
  modport source (output valid, kind, glyph_id, input ready);
  modport sink (input valid, kind, glyph_id, output ready);
endinterface

interface sld_out_if;
  logic                        valid;
  logic                        ready;
  logic                        drive;
  logic                        clear;
  logic [sld_pkg::SCAN_W-1:0]  row_off;
  logic [sld_pkg::SCAN_W-1:0]  row_on;
  logic [sld_pkg::COL_W-1:0]   columns;
  logic                        busy_res;
  modport source (output valid, drive, clear, row_off, row_on, columns, busy_res,
                  input ready);
  modport sink (input valid, drive, clear, row_off, row_on, columns, busy_res,
                output ready);
endinterface

interface sld_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sld_pkg::PERIOD_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* hw/rtl/sld_step.sv */
// Next-state and result logic for one item.
module sld_step (
  input  sld_pkg::state_t              st,
  input  logic                         kind,
  input  logic [sld_pkg::GLYPH_W-1:0]  glyph_id,
  input  logic [sld_pkg::PERIOD_W-1:0] period,
  output sld_pkg::state_t              st_nxt,
  output sld_pkg::result_t             res
);

  always_comb begin
    logic [sld_pkg::PRIO_W-1:0] prio;
    logic                       show;
    logic [sld_pkg::POS_W-1:0]  top;
    logic [sld_pkg::SCAN_W-1:0] line;
    st_nxt = st;
    res    = '0;
    prio   = sld_pkg::PRIO_W'(glyph_id) + sld_pkg::PRIO_W'(1);
    show   = 1'b1;
    line   = st.scan_row;
    top    = '0;
    if (kind == sld_pkg::KIND_REQUEST) begin
      if (32'(glyph_id) < 32'(sld_pkg::GLYPH_COUNT) && st.pend_prio < prio) begin
        st_nxt.pend_prio  = prio;
        st_nxt.pend_glyph = glyph_id;
      end
    end else if (st.work_prio != sld_pkg::PRIO_EMPTY ||
                 st.pend_prio != sld_pkg::PRIO_EMPTY) begin
      // Idle working slot takes over the pending glyph and blanks the matrix.
      if (st.work_prio == sld_pkg::PRIO_EMPTY) begin
        st_nxt.work_prio  = st.pend_prio;
        st_nxt.work_glyph = st.pend_glyph;
        st_nxt.position   = '0;
        st_nxt.pend_prio  = sld_pkg::PRIO_EMPTY;
        res.clear         = 1'b1;
      end
      if (st.prescale >= period) begin
        st_nxt.prescale = '0;
        st_nxt.position = st_nxt.position + sld_pkg::POS_W'(1);
        if (st_nxt.position > sld_pkg::RETIRE_POS) begin
          st_nxt.work_prio = sld_pkg::PRIO_EMPTY;
          show             = 1'b0;
        end
      end else begin
        st_nxt.prescale = st.prescale + sld_pkg::PERIOD_W'(1);
      end
      if (show) begin
        top = st_nxt.position + sld_pkg::POS_W'(line);
        if (top >= sld_pkg::WINDOW_OFS &&
            (top - sld_pkg::WINDOW_OFS) < sld_pkg::POS_W'(sld_pkg::GLYPH_ROWS)) begin
          res.columns = sld_pkg::glyph_row(st_nxt.work_glyph, top - sld_pkg::WINDOW_OFS);
        end
        res.row_off     = line - sld_pkg::SCAN_W'(1);
        res.row_on      = line;
        res.drive       = 1'b1;
        st_nxt.scan_row = line + sld_pkg::SCAN_W'(1);
      end
    end
    res.busy_res = (st_nxt.work_prio != sld_pkg::PRIO_EMPTY);
  end

endmodule

/* hw/rtl/scrolling_led_matrix_driver.sv */
// Top level of the scrolling LED matrix driver: state, period and result registers.
// Every item (a display tick or a glyph request) yields exactly one result item in the
// cycle after it is accepted; a new item is taken every cycle while the result
// register is empty or being drained, so the sustained rate is one item per clock.
// That figure is set by the single register stage between the item and the result;
// the glyph patterns are a constant lookup and need no warm-up after reset. The
// scroll period register (reset 200) is written through the cfg channel, which is
// always ready; write it only while no item is in flight.
module scrolling_led_matrix_driver (
  input  logic             clk,
  input  logic             rst_n,
  sld_in_if.sink           in_chan,
  sld_out_if.source        out_chan,
  sld_cfg_if.sink          cfg_chan
);

  sld_pkg::state_t              state_r;
  sld_pkg::state_t              state_nxt;
  sld_pkg::result_t             res_r;
  sld_pkg::result_t             res_nxt;
  logic                         out_valid_r;
  logic [sld_pkg::PERIOD_W-1:0] period_r;
  logic                         in_fire;

  // Take a new item whenever the result register frees up this cycle.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  sld_step u_step (
    .st       (state_r),
    .kind     (in_chan.kind),
    .glyph_id (in_chan.glyph_id),
    .period   (period_r),
    .st_nxt   (state_nxt),
    .res      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
      period_r    <= sld_pkg::PERIOD_RESET;
    end else begin
      if (cfg_chan.valid) begin
        period_r <= cfg_chan.data;
      end
      if (in_fire) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.drive    = res_r.drive;
  assign out_chan.clear    = res_r.clear;
  assign out_chan.row_off  = res_r.row_off;
  assign out_chan.row_on   = res_r.row_on;
  assign out_chan.columns  = res_r.columns;
  assign out_chan.busy_res = res_r.busy_res;

endmodule
